/* hw/rtl/ius2x_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ius2x_pkg;

	// Width used for frame-size arithmetic (holds sizes up to 8191).
	localparam int DIM_W = 13;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [10:0] SIZE_RESET = 11'd1024;

	typedef logic [23:0] pixel_t;   // {blue, green, red}
	typedef logic [9:0]  quarter_t; // channel value in quarter units

	// Result currently produced by the emitter.
	typedef enum logic [3:0] {
		PH_ORIG = 4'b0001,
		PH_HMID = 4'b0010,
		PH_VMID = 4'b0100,
		PH_CTR  = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

/* hw/rtl/image_upscale_2x_bilinear_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// A pixel's first result passes through the stage 1 register, the emitter register and the output register.
// Throughput: one result per cycle while out_stall is low; a pixel causes 1 to 4 results, all from
// the single result emitter, so a full-frame interior pixel holds the emitter for four results.
// Reset (arst_n low, asynchronous): pipeline empty, position counters zero, neighbor pixels zero,
// frame_width and frame_height 1024. The row memory is not cleared; row 0 results never use it.

module image_upscale_2x_bilinear_core
	import ius2x_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_write_en,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data,
	// input pixels
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	// results
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [10:0] out_row,
	output      logic [10:0] out_col,
	output      logic [9:0]  red_out,
	output      logic [9:0]  green_out,
	output      logic [9:0]  blue_out,
	output      logic        last_of_input,
	output      logic        frame_done
);

	localparam int AW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RHW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [10:0] frame_width_q;
	logic [10:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_RESET;
			frame_height_q <= SIZE_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the sizes into 2..MAX.
	logic [DIM_W-1:0] fw_ext, fh_ext, w_eff, h_eff;

	always_comb begin
		fw_ext = {{(DIM_W-11){1'b0}}, frame_width_q};
		fh_ext = {{(DIM_W-11){1'b0}}, frame_height_q};
		if (fw_ext < DIM_W'(2))
			w_eff = DIM_W'(2);
		else if (fw_ext > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = fw_ext;
		if (fh_ext < DIM_W'(2))
			h_eff = DIM_W'(2);
		else if (fh_ext > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = fh_ext;
	end

	// ------------------------------------------------------------------
	// Handshake control
	// ------------------------------------------------------------------
	logic   s1_valid_q, s2_valid_q, out_valid_q;
	phase_t phase_q, phase_next;
	logic   phase_last;
	logic   out_load, s2_done, s2_load, in_acc;

	// Load the output register whenever it is empty or being drained.
	assign out_load = s2_valid_q && (!out_valid_q || !out_stall);
	assign s2_done  = out_load && phase_last;
	// Move the waiting pixel into the emitter when it frees up.
	assign s2_load  = s1_valid_q && (!s2_valid_q || s2_done);
	assign in_stall = s1_valid_q && !s2_load;
	assign in_acc   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Position counters
	// ------------------------------------------------------------------
	logic [AW-1:0]    col_q;
	logic [RHW-1:0]   row_q;
	logic [DIM_W-1:0] col_next_ext, row_next_ext;
	logic             row_end, frame_end;

	assign col_next_ext = {{(DIM_W-AW){1'b0}}, col_q} + DIM_W'(1);
	assign row_next_ext = {{(DIM_W-RHW){1'b0}}, row_q} + DIM_W'(1);
	assign row_end      = col_next_ext >= w_eff;
	assign frame_end    = row_end && (row_next_ext >= h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_next_ext[RHW-1:0];
			end else begin
				col_q <= col_next_ext[AW-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Row memory: read the pixel above and overwrite it with the current
	// pixel in the same cycle (read returns the old entry). Consecutive
	// pixels never share a column, so no forwarding is needed.
	// ------------------------------------------------------------------
	pixel_t row_mem [MAX_WIDTH];
	pixel_t mem_rd_q;
	pixel_t cur_pix;

	assign cur_pix = {blue_in, green_in, red_in};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem_rd_q     <= row_mem[col_q];
			row_mem[col_q] <= cur_pix;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: accepted pixel waiting for memory data / the emitter
	// ------------------------------------------------------------------
	pixel_t         left_q;
	pixel_t         prev_above_q;
	pixel_t         cur_s1, left_s1;
	logic [AW-1:0]  col_s1;
	logic [RHW-1:0] row_s1;
	logic           fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			left_q     <= '0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
				left_q     <= cur_pix;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1  <= cur_pix;
			left_s1 <= left_q;
			col_s1  <= col_q;
			row_s1  <= row_q;
			fend_s1 <= frame_end;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: emitter, while out_stall is low one result per cycle
	// ------------------------------------------------------------------
	pixel_t         cur_s2, left_s2, above_s2, aleft_s2;
	logic [AW-1:0]  col_s2;
	logic [RHW-1:0] row_s2;
	logic           fend_s2;
	logic           col_nz, row_nz;

	assign col_nz = col_s2 != '0;
	assign row_nz = row_s2 != '0;

	// Skip the midpoints that fall outside the frame.
	always_comb begin
		phase_next = PH_ORIG;
		phase_last = 1'b1;
		case (phase_q)
			PH_ORIG: begin
				if (col_nz) begin
					phase_next = PH_HMID;
					phase_last = 1'b0;
				end else if (row_nz) begin
					phase_next = PH_VMID;
					phase_last = 1'b0;
				end
			end
			PH_HMID: begin
				if (row_nz) begin
					phase_next = PH_VMID;
					phase_last = 1'b0;
				end
			end
			PH_VMID: begin
				if (col_nz) begin
					phase_next = PH_CTR;
					phase_last = 1'b0;
				end
			end
			PH_CTR:  phase_last = 1'b1;
			default: phase_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q   <= 1'b0;
			phase_q      <= PH_ORIG;
			prev_above_q <= '0;
		end else begin
			if (s2_load) begin
				s2_valid_q   <= 1'b1;
				phase_q      <= PH_ORIG;
				prev_above_q <= mem_rd_q;
			end else if (s2_done) begin
				s2_valid_q <= 1'b0;
			end else if (out_load) begin
				phase_q <= phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			cur_s2   <= cur_s1;
			left_s2  <= left_s1;
			above_s2 <= mem_rd_q;
			aleft_s2 <= prev_above_q;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			fend_s2  <= fend_s1;
		end
	end

	// Channel values and coordinates of the current result.
	quarter_t        chan_val [3];
	logic [RHW+11:0] row_calc;
	logic [AW+11:0]  col_calc;
	logic            row_dec, col_dec;

	always_comb begin
		quarter_t cc, lc, ac, dc;
		for (int k = 0; k < 3; k++) begin
			cc = {2'b00, cur_s2[8*k +: 8]};
			lc = {2'b00, left_s2[8*k +: 8]};
			ac = {2'b00, above_s2[8*k +: 8]};
			dc = {2'b00, aleft_s2[8*k +: 8]};
			case (phase_q)
				PH_ORIG: chan_val[k] = cc << 2;
				PH_HMID: chan_val[k] = (cc + lc) << 1;
				PH_VMID: chan_val[k] = (cc + ac) << 1;
				PH_CTR:  chan_val[k] = cc + ac + lc + dc;
				default: chan_val[k] = cc << 2;
			endcase
		end
	end

	assign row_dec  = (phase_q == PH_VMID) || (phase_q == PH_CTR);
	assign col_dec  = (phase_q == PH_HMID) || (phase_q == PH_CTR);
	assign row_calc = {11'd0, row_s2, 1'b0} - {{(RHW+11){1'b0}}, row_dec};
	assign col_calc = {11'd0, col_s2, 1'b0} - {{(AW+11){1'b0}}, col_dec};

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [10:0] out_row_q, out_col_q;
	quarter_t    red_q, green_q, blue_q;
	logic        last_q, fdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q <= row_calc[10:0];
			out_col_q <= col_calc[10:0];
			red_q     <= chan_val[0];
			green_q   <= chan_val[1];
			blue_q    <= chan_val[2];
			last_q    <= phase_last;
			fdone_q   <= phase_last && fend_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign red_out       = red_q;
	assign green_out     = green_q;
	assign blue_out      = blue_q;
	assign last_of_input = last_q;
	assign frame_done    = fdone_q;

`ifndef ASSERT_OFF
	// Frame end always rides on the last result of a pixel.
	a_fdone_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fdone_q |-> last_q)
		else $error("frame_done without last_of_input");

	// A result that is not the last one leaves the emitter still busy.
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> s2_valid_q)
		else $error("emitter empty while results of a pixel remain");

	// Midpoints exist only away from the top-left corner.
	a_corner_single: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && (phase_q != PH_ORIG) |-> (col_nz || row_nz))
		else $error("midpoint emitted for first pixel of a frame");

	// An accepted pixel is held in stage 1 on the next cycle.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q)
		else $error("accepted pixel lost");
`endif

endmodule

`default_nettype wire

/* test/upscale_checker.sv */
`timescale 1ns / 1ps

module upscale_checker
	import ius2x_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [10:0] out_row,
	input  wire logic [10:0] out_col,
	input  wire logic [9:0]  red_out,
	input  wire logic [9:0]  green_out,
	input  wire logic [9:0]  blue_out,
	input  wire logic        last_of_input,
	input  wire logic        frame_done,
	output int               mismatch_count,
	output int               pending_results
);

	localparam int MAX_DIM = 1024;

	typedef struct packed {
		logic [10:0] row;
		logic [10:0] col;
		quarter_t    red;
		quarter_t    green;
		quarter_t    blue;
		logic        last;
		logic        done;
	} upscaled_px_t;

	upscaled_px_t expected_results[$];

	pixel_t      row_above [MAX_DIM];
	pixel_t      left_px;
	pixel_t      above_left_px;
	int          row_pos;
	int          col_pos;
	logic [10:0] width_reg;
	logic [10:0] height_reg;

	function automatic int clamp_dim(input logic [10:0] v);
		if (v < 2)
			return 2;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic quarter_t chan_sum(input pixel_t a, input pixel_t b, input pixel_t c,
		input pixel_t d, input int k);
		return quarter_t'(a[8*k +: 8]) + quarter_t'(b[8*k +: 8]) + quarter_t'(c[8*k +: 8])
			+ quarter_t'(d[8*k +: 8]);
	endfunction

	// Sum of four pixels in quarter units; pass a pixel twice for a midpoint,
	// four times for an original.
	function automatic upscaled_px_t blend(input int row, input int col, input pixel_t a,
		input pixel_t b, input pixel_t c, input pixel_t d);
		upscaled_px_t px;
		px.row   = 11'(row);
		px.col   = 11'(col);
		px.red   = chan_sum(a, b, c, d, 0);
		px.green = chan_sum(a, b, c, d, 1);
		px.blue  = chan_sum(a, b, c, d, 2);
		px.last  = 1'b0;
		px.done  = 1'b0;
		return px;
	endfunction

	task automatic predict_upscale(input pixel_t cur);
		int           w;
		int           h;
		int           n;
		pixel_t       above;
		bit           row_end;
		bit           frame_end;
		upscaled_px_t batch[4];
		w         = clamp_dim(width_reg);
		h         = clamp_dim(height_reg);
		above     = row_above[col_pos];
		row_end   = (col_pos + 1 >= w);
		frame_end = row_end && (row_pos + 1 >= h);

		batch[0] = blend(2 * row_pos, 2 * col_pos, cur, cur, cur, cur);
		n = 1;
		if (col_pos > 0) begin
			batch[n] = blend(2 * row_pos, 2 * col_pos - 1, cur, cur, left_px, left_px);
			n++;
		end
		if (row_pos > 0) begin
			batch[n] = blend(2 * row_pos - 1, 2 * col_pos, cur, cur, above, above);
			n++;
		end
		if (row_pos > 0 && col_pos > 0) begin
			batch[n] = blend(2 * row_pos - 1, 2 * col_pos - 1, cur, above, left_px,
				above_left_px);
			n++;
		end
		batch[n - 1].last = 1'b1;
		batch[n - 1].done = frame_end;
		for (int i = 0; i < n; i++)
			expected_results.push_back(batch[i]);

		// advance neighbors and position
		above_left_px     = above;
		row_above[col_pos] = cur;
		left_px           = cur;
		if (row_end) begin
			col_pos = 0;
			row_pos = frame_end ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic check_field(input string name, input logic [10:0] want,
		input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic compare_result();
		upscaled_px_t want;
		if (expected_results.size() == 0) begin
			$error("result with nothing pending: row %0d col %0d", out_row, out_col);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			check_field("out_row", want.row, out_row);
			check_field("out_col", want.col, out_col);
			check_field("red_out", 11'(want.red), 11'(red_out));
			check_field("green_out", 11'(want.green), 11'(green_out));
			check_field("blue_out", 11'(want.blue), 11'(blue_out));
			check_field("last_of_input", 11'(want.last), 11'(last_of_input));
			check_field("frame_done", 11'(want.done), 11'(frame_done));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			for (int i = 0; i < MAX_DIM; i++)
				row_above[i] = '0;
			left_px         = '0;
			above_left_px   = '0;
			row_pos         = 0;
			col_pos         = 0;
			width_reg       = SIZE_RESET;
			height_reg      = SIZE_RESET;
			mismatch_count  = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				predict_upscale({blue_in, green_in, red_in});
			if (cfg_write_en) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
		end
		pending_results = expected_results.size();
	end

endmodule

/* test/tb_image_upscale_2x_bilinear_core.sv */
`timescale 1ns / 1ps

module tb_image_upscale_2x_bilinear_core;
	import ius2x_pkg::*;

	localparam int MAX_DIM    = 1024;
	localparam int RAND_ITEMS = 210;
	// last stretch of the random part runs with no random idling on either side
	localparam int CALM_TAIL  = 50;
	// leading row memory columns written by the directed part; no later pixel
	// goes past them
	localparam int FILL_COLS  = 64;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_index    = REG_FRAME_WIDTH;
	logic [10:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic [7:0]  red_in       = '0;
	logic [7:0]  green_in     = '0;
	logic [7:0]  blue_in      = '0;
	logic        out_stall    = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [10:0] out_row;
	logic [10:0] out_col;
	logic [9:0]  red_out;
	logic [9:0]  green_out;
	logic [9:0]  blue_out;
	logic        last_of_input;
	logic        frame_done;

	int mismatch_count;
	int pending_results;

	// Stimulus-side bookkeeping: effective frame size and the position of the
	// next pixel, used only to shape whole frames.
	bit quiet   = 1'b0;
	int frame_w = MAX_DIM;
	int frame_h = MAX_DIM;
	int row_pos = 0;
	int col_pos = 0;
	int sent    = 0;
	int base;

	image_upscale_2x_bilinear_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_row       (out_row),
		.out_col       (out_col),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.last_of_input (last_of_input),
		.frame_done    (frame_done)
	);

	upscale_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_row         (out_row),
		.out_col         (out_col),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.last_of_input   (last_of_input),
		.frame_done      (frame_done),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard ceiling on the run: far beyond the slowest legal run
	// (every pixel with four results, each under the longest stall).
	initial begin
		#8_500_000;
		$display("== FAIL ==");
		$finish;
	end

	// Result side: alternate stall bursts with free-running stretches; drop
	// stalls entirely once the calm tail starts.
	initial begin
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(11, 1)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(24, 1)) @(posedge clk);
			end
		end
	end

	function automatic int clamp_dim(input logic [10:0] v);
		if (v < 2)
			return 2;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// Random pixel; now and then force a channel to an extreme.
	function automatic pixel_t random_pixel();
		pixel_t px;
		px = pixel_t'($urandom);
		for (int k = 0; k < 3; k++)
			if ($urandom_range(7) == 0)
				px[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
		return px;
	endfunction

	function automatic logic [10:0] odd_size();
		if ($urandom_range(1))
			return 11'($urandom_range(1));
		return 11'($urandom_range(2047, MAX_DIM + 1));
	endfunction

	// Drive one pixel transaction and hold it until accepted. Valid stays high
	// afterwards so back-to-back pixels need no extra assignment.
	task automatic send_pixel(input pixel_t px);
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(11, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{blue_in, green_in, red_in} <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// advance the stimulus-side position
		if (col_pos + 1 >= frame_w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= frame_h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
		sent++;
	endtask

	// Finish the frame in progress, or send one whole frame from its start.
	task automatic send_frame_rest();
		do
			send_pixel(random_pixel());
		while (row_pos != 0 || col_pos != 0);
	endtask

	// Hold off the sender until every pending result has been taken. The first
	// edge lets the checker register the last transaction before it is polled.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	// Write frame size registers, only with the block idle.
	task automatic program_size(input bit set_w, input logic [10:0] w, input bit set_h,
		input logic [10:0] h);
		drain();
		if (set_w) begin
			cfg_write_en <= 1'b1;
			cfg_index    <= REG_FRAME_WIDTH;
			cfg_data     <= w;
			@(posedge clk);
			frame_w = clamp_dim(w);
		end
		if (set_h) begin
			cfg_write_en <= 1'b1;
			cfg_index    <= REG_FRAME_HEIGHT;
			cfg_data     <= h;
			@(posedge clk);
			frame_h = clamp_dim(h);
		end
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sizes below range act as 2x2; saturate the centre sum, then
		// all zeros, then one channel at a time.
		program_size(1'b1, 11'd0, 1'b1, 11'd1);
		repeat (4) send_pixel(24'hFFFFFF);
		repeat (4) send_pixel(24'h000000);
		send_pixel(24'h0000FF);
		send_pixel(24'h00FF00);
		send_pixel(24'hFF0000);
		send_pixel(24'h55AA55);

		// Shrink both sizes mid-frame with both counters past the new last
		// position: the next pixel must close its row and the frame.
		program_size(1'b1, 11'd5, 1'b1, 11'd4);
		repeat (12) send_pixel(random_pixel());
		program_size(1'b1, 11'd2, 1'b1, 11'd2);
		send_frame_rest();

		// Width above range saturates at the maximum; fill the leading columns
		// of row 0 so every column that later frames reach is written, then
		// narrow to 2 and shorten to 3 rows mid-frame.
		program_size(1'b1, 11'h7FF, 1'b1, SIZE_RESET);
		repeat (FILL_COLS) send_pixel(random_pixel());
		program_size(1'b1, 11'd2, 1'b1, 11'd3);
		send_frame_rest();

		// Random part: mostly whole small frames, some mid-frame size changes and
		// out-of-range sizes with broken-off frames.
		base = sent;
		while (sent < base + RAND_ITEMS) begin
			quiet = (sent >= base + RAND_ITEMS - CALM_TAIL);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					program_size(1'b1, 11'($urandom_range(8, 2)), 1'b1,
						11'($urandom_range(5, 2)));
					repeat ($urandom_range(2, 1)) send_frame_rest();
				end
				6, 7: begin
					if ($urandom_range(1))
						program_size(1'b1, 11'($urandom_range(9, 2)), 1'b0, 11'd0);
					else
						program_size(1'b0, 11'd0, 1'b1, 11'($urandom_range(6, 2)));
					repeat ($urandom_range(15, 1)) send_pixel(random_pixel());
				end
				default: begin
					program_size(1'b1, odd_size(), 1'b1, odd_size());
					// stay inside the filled columns
					repeat ($urandom_range(20, 1))
						if (col_pos < FILL_COLS - 1)
							send_pixel(random_pixel());
				end
			endcase
		end

		quiet = 1'b1;
		drain();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
